FILE: design/keyed_stack_with_remove_macros.svh
// Assertion macros for the keyed stack top level.
`ifndef KEYED_STACK_WITH_REMOVE_MACROS_SVH
`define KEYED_STACK_WITH_REMOVE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("keyed stack check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("keyed stack check failed");

`endif

FILE: design/ksr_pkg.sv
// Shared types and codes for the keyed stack.
package ksr_pkg;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;
    localparam int KEY_PORT_W = 16;
    localparam int TAG_PORT_W = 64;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LIST   = 2'd2,
        CMD_CLEAR  = 2'd3
    } ksr_cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_MISSING = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4,
        ST_LISTED  = 3'd5
    } ksr_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } ksr_state_t;

    typedef struct packed {
        logic occupied;
        logic load;
        logic remove;
    } ksr_cell_ctrl_t;

endpackage

FILE: design/ksr_cell.sv
// One stack slot: holds a key and tag, matches the key, shifts down on remove.
module ksr_cell
    import ksr_pkg::*;
#(
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 64
) (
    input  logic                aclk,
    input  ksr_cell_ctrl_t      ctrl,
    input  logic [KEY_BITS-1:0] in_key,
    input  logic [TAG_BITS-1:0] in_tag,
    input  logic [KEY_BITS-1:0] nbr_key,
    input  logic [TAG_BITS-1:0] nbr_tag,
    input  logic                seen_in,
    output logic [KEY_BITS-1:0] key_out,
    output logic [TAG_BITS-1:0] tag_out,
    output logic                hit,
    output logic                seen_out
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;

    assign hit      = ctrl.occupied && (key_reg == in_key);
    assign seen_out = seen_in | hit;
    assign key_out  = key_reg;
    assign tag_out  = tag_reg;

    always_comb begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.load) begin
            key_next = in_key;
            tag_next = in_tag;
        end else if (ctrl.remove && seen_out) begin
            key_next = nbr_key;
            tag_next = nbr_tag;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

FILE: design/keyed_stack_with_remove.sv
// Keyed stack with remove-by-key: top level with control and result register.
//
// Input channel s_*: one command per transaction (push, remove by key, list, clear).
// Result channel m_*: status transactions; m_tlast marks the final result of a command.
// Push and remove are matched against all occupied slots at once; push, remove and clear
// give one registered result in the cycle after acceptance. A list of N entries first
// enters the list state and then emits one entry per cycle while the receiver does not
// stall, top of stack first; the index register into the slot row sets that pace.
// A list of an empty stack gives a single empty status with m_tlast set.
// Commands are taken one at a time: s_tready is low while a list is being emitted
// and while a result waits in the output register with m_tready low.
// When the receiver stalls, the result register holds its transaction and no new
// command is taken. Reset empties the stack and drops any pending result; slot
// contents are not cleared and need no clearing pass.
module keyed_stack_with_remove
    import ksr_pkg::*;
#(
    parameter int DEPTH    = 32,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // command[1:0], item_key[17:2], item_tag[81:18]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // status[2:0], out_key[18:3], out_tag[82:19]
    output logic                  m_tlast
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ksr_cmd_t            cmd;
    logic [KEY_BITS-1:0] in_key;
    logic [TAG_BITS-1:0] in_tag;

    ksr_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic                m_valid_reg, m_valid_next;
    ksr_status_t         m_status_reg, m_status_next;
    logic [KEY_BITS-1:0] m_key_reg, m_key_next;
    logic [TAG_BITS-1:0] m_tag_reg, m_tag_next;
    logic                m_last_reg, m_last_next;

    logic                s_acc, out_free, any_hit, full, push_go, remove_go, res_load;

    ksr_cell_ctrl_t      ctrl     [DEPTH];
    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [TAG_BITS-1:0] cell_tag [DEPTH];
    logic [DEPTH-1:0]    hit;
    logic [DEPTH-1:0]    seen;

    assign cmd    = ksr_cmd_t'(s_tdata[1:0]);
    assign in_key = KEY_BITS'(s_tdata[17:2]);
    assign in_tag = TAG_BITS'(s_tdata[81:18]);

    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign any_hit   = |hit;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign push_go   = s_acc && (cmd == CMD_PUSH) && !any_hit && !full;
    assign remove_go = s_acc && (cmd == CMD_REMOVE) && any_hit;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_BITS-1:0] nbr_key;
        logic [TAG_BITS-1:0] nbr_tag;
        logic                seen_in;

        if (i == DEPTH - 1) begin : g_top
            assign nbr_key = cell_key[i];
            assign nbr_tag = cell_tag[i];
        end else begin : g_mid
            assign nbr_key = cell_key[i+1];
            assign nbr_tag = cell_tag[i+1];
        end

        if (i == 0) begin : g_bot
            assign seen_in = 1'b0;
        end else begin : g_up
            assign seen_in = seen[i-1];
        end

        assign ctrl[i].occupied = (CNT_W'(i) < count_reg);
        assign ctrl[i].load     = push_go && (count_reg == CNT_W'(i));
        assign ctrl[i].remove   = remove_go;

        ksr_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl[i]),
            .in_key   (in_key),
            .in_tag   (in_tag),
            .nbr_key  (nbr_key),
            .nbr_tag  (nbr_tag),
            .seen_in  (seen_in),
            .key_out  (cell_key[i]),
            .tag_out  (cell_tag[i]),
            .hit      (hit[i]),
            .seen_out (seen[i])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc && (cmd == CMD_LIST) && (count_reg != '0)) begin
                    state_next = S_LIST;
                end
            end
            S_LIST: begin
                if (out_free && (cursor_reg == '0)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_tready      = 1'b0;
        res_load      = 1'b0;
        m_status_next = m_status_reg;
        m_key_next    = m_key_reg;
        m_tag_next    = m_tag_reg;
        m_last_next   = m_last_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = out_free;
                if (s_acc) begin
                    res_load      = 1'b1;
                    m_key_next    = '0;
                    m_tag_next    = '0;
                    m_last_next   = 1'b1;
                    m_status_next = ST_OK;
                    case (cmd)
                        CMD_PUSH: begin
                            if (any_hit) begin
                                m_status_next = ST_DUP;
                            end else if (full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (any_hit) begin
                                count_next = count_reg - 1'b1;
                            end else begin
                                m_status_next = ST_MISSING;
                            end
                        end
                        CMD_LIST: begin
                            if (count_reg == '0) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                res_load    = 1'b0;
                                cursor_next = IDX_W'(count_reg - 1'b1);
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_LIST: begin
                if (out_free) begin
                    res_load      = 1'b1;
                    m_status_next = ST_LISTED;
                    m_key_next    = cell_key[cursor_reg];
                    m_tag_next    = cell_tag[cursor_reg];
                    m_last_next   = (cursor_reg == '0);
                    cursor_next   = cursor_reg - 1'b1;
                end
            end
            default: ;
        endcase
        m_valid_next = res_load ? 1'b1 : (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_status_reg <= m_status_next;
            m_key_reg    <= m_key_next;
            m_tag_reg    <= m_tag_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'b0, TAG_PORT_W'(m_tag_reg), KEY_PORT_W'(m_key_reg), m_status_reg};

`include "keyed_stack_with_remove_macros.svh"

    `KSR_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `KSR_ASSERT_IMP(a_unique_hit, aclk, aresetn, 1'b1, $onehot0(hit))
    `KSR_ASSERT_NXT(a_push_grows, aclk, aresetn, push_go, count_reg == $past(count_reg) + 1'b1)
    `KSR_ASSERT_IMP(a_list_cursor, aclk, aresetn, state_reg == S_LIST, CNT_W'(cursor_reg) < count_reg)

endmodule

FILE: tb/keyed_stack_with_remove_checker.sv
// Watches both stream channels of the keyed stack, mirrors its contents and checks every result.
`timescale 1ns / 100ps

module keyed_stack_with_remove_checker
    import ksr_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // command[1:0], item_key[17:2], item_tag[81:18]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // status[2:0], out_key[18:3], out_tag[82:19]
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    outstanding
);

    typedef struct {
        ksr_status_t            status;
        logic [KEY_PORT_W-1:0]  key;
        logic [TAG_PORT_W-1:0]  tag;
        logic                   last;
    } stack_result_t;

    stack_result_t         owed_results[$];
    logic [KEY_PORT_W-1:0] mirror_keys[DEPTH];
    logic [TAG_PORT_W-1:0] mirror_tags[DEPTH];
    int                    mirror_fill;

    initial fail_count = 0;

    function automatic int slot_of(logic [KEY_PORT_W-1:0] key);
        for (int i = 0; i < mirror_fill; i++) begin
            if (mirror_keys[i] == key) return i;
        end
        return -1;
    endfunction

    task automatic owe(ksr_status_t status, logic [KEY_PORT_W-1:0] key,
                       logic [TAG_PORT_W-1:0] tag, logic last);
        stack_result_t r;
        r.status = status;
        r.key    = key;
        r.tag    = tag;
        r.last   = last;
        owed_results.push_back(r);
    endtask

    task automatic replay_command(ksr_cmd_t cmd, logic [KEY_PORT_W-1:0] key,
                                  logic [TAG_PORT_W-1:0] tag);
        int pos;
        case (cmd)
            CMD_PUSH: begin
                if (slot_of(key) >= 0) begin
                    owe(ST_DUP, '0, '0, 1'b1);
                end else if (mirror_fill >= DEPTH) begin
                    owe(ST_FULL, '0, '0, 1'b1);
                end else begin
                    mirror_keys[mirror_fill] = key;
                    mirror_tags[mirror_fill] = tag;
                    mirror_fill++;
                    owe(ST_OK, '0, '0, 1'b1);
                end
            end
            CMD_REMOVE: begin
                pos = slot_of(key);
                if (pos < 0) begin
                    owe(ST_MISSING, '0, '0, 1'b1);
                end else begin
                    for (int i = pos; i + 1 < mirror_fill; i++) begin
                        mirror_keys[i] = mirror_keys[i+1];
                        mirror_tags[i] = mirror_tags[i+1];
                    end
                    mirror_fill--;
                    owe(ST_OK, '0, '0, 1'b1);
                end
            end
            CMD_LIST: begin
                if (mirror_fill == 0) begin
                    owe(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int i = mirror_fill - 1; i >= 0; i--)
                        owe(ST_LISTED, mirror_keys[i], mirror_tags[i], i == 0);
                end
            end
            default: begin
                mirror_fill = 0;
                owe(ST_OK, '0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_result();
        stack_result_t want;
        ksr_status_t   got_status;
        got_status = ksr_status_t'(m_tdata[2:0]);
        if (owed_results.size() == 0) begin
            $error("unexpected result transaction: status %0d key %0h tag %0h last %0b",
                   m_tdata[2:0], m_tdata[18:3], m_tdata[82:19], m_tlast);
            fail_count++;
            return;
        end
        want = owed_results.pop_front();
        if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
            fail_count++;
        end
        if (m_tdata[18:3] !== want.key) begin
            $error("out_key: expected %0h, actual %0h", want.key, m_tdata[18:3]);
            fail_count++;
        end
        if (m_tdata[82:19] !== want.tag) begin
            $error("out_tag: expected %0h, actual %0h", want.tag, m_tdata[82:19]);
            fail_count++;
        end
        if (m_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_tlast);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            owed_results.delete();
            mirror_fill = 0;
        end else begin
            // results always trail their command, so check before predicting
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready)
                replay_command(ksr_cmd_t'(s_tdata[1:0]), s_tdata[17:2], s_tdata[81:18]);
        end
        outstanding = owed_results.size();
    end

endmodule

FILE: tb/keyed_stack_with_remove_tb.sv
// Top of the keyed stack testbench: clock, reset, command stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module keyed_stack_with_remove_tb;
    import ksr_pkg::*;

    localparam int STACK_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT  = 600000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // command[1:0], item_key[17:2], item_tag[81:18]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // status[2:0], out_key[18:3], out_tag[82:19]
    logic                  m_tlast;

    int fail_count;
    int outstanding;
    int cycles = 0;
    int items_sent = 0;
    int burst_left = 0;
    logic [KEY_PORT_W-1:0] held_keys[$];

    keyed_stack_with_remove #(
        .DEPTH(STACK_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    keyed_stack_with_remove_checker #(
        .DEPTH(STACK_DEPTH)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int held_index(logic [KEY_PORT_W-1:0] key);
        for (int i = 0; i < held_keys.size(); i++) begin
            if (held_keys[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic logic [TAG_PORT_W-1:0] rand_tag();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_PORT_W-1:0] fresh_key();
        logic [KEY_PORT_W-1:0] k;
        do k = KEY_PORT_W'($urandom_range(0, 65535)); while (held_index(k) >= 0);
        return k;
    endfunction

    function automatic logic [KEY_PORT_W-1:0] some_held_key();
        if (held_keys.size() == 0) return KEY_PORT_W'($urandom_range(0, 47));
        return held_keys[$urandom_range(0, held_keys.size() - 1)];
    endfunction

    // one command transaction; valid stays up across back-to-back transactions
    task automatic offer(ksr_cmd_t cmd, logic [KEY_PORT_W-1:0] key,
                         logic [TAG_PORT_W-1:0] tag);
        int gap;
        int idx;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= IN_DATA_W'({rand_tag(), 18'($urandom)});
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({tag, key, cmd});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        case (cmd)
            CMD_PUSH: begin
                if (held_index(key) < 0 && held_keys.size() < STACK_DEPTH)
                    held_keys.push_back(key);
            end
            CMD_REMOVE: begin
                idx = held_index(key);
                if (idx >= 0) held_keys.delete(idx);
            end
            CMD_CLEAR: held_keys.delete();
            default: ;
        endcase
    endtask

    // fill to capacity, then a held key must still report duplicate, a new one full
    task automatic fill_to_capacity();
        offer(CMD_CLEAR, KEY_PORT_W'($urandom_range(0, 65535)), rand_tag());
        while (held_keys.size() < STACK_DEPTH) offer(CMD_PUSH, fresh_key(), rand_tag());
        offer(CMD_PUSH, some_held_key(), rand_tag());
        offer(CMD_PUSH, fresh_key(), rand_tag());
        offer(CMD_LIST, KEY_PORT_W'($urandom_range(0, 65535)), rand_tag());
        offer(CMD_REMOVE, some_held_key(), rand_tag());
        offer(CMD_PUSH, fresh_key(), rand_tag());
        offer(CMD_LIST, '0, '0);
    endtask

    initial begin : receiver
        int seen;
        int span;
        int mode;
        int k;
        bit held_off;
        seen = 0;
        held_off = 1'b0;
        forever begin
            if (!held_off && seen >= 120) begin
                held_off = 1'b1;
                for (int n = 0; n < 400; n++) begin
                    @(posedge aclk);
                    if (m_tvalid && m_tready) seen++;
                    m_tready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 60);
            k    = $urandom_range(2, 4);
            for (int n = 0; n < span; n++) begin
                @(posedge aclk);
                if (m_tvalid && m_tready) seen++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (n % k == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int pick;
        int n;
        logic [KEY_PORT_W-1:0] key;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(CMD_LIST,   16'h0000, 64'h0);
        offer(CMD_REMOVE, 16'h1234, 64'h0);
        offer(CMD_CLEAR,  16'h0000, 64'h0);
        offer(CMD_PUSH,   16'h0000, 64'h0);
        offer(CMD_PUSH,   16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        offer(CMD_PUSH,   16'h8001, 64'hA5A5_A5A5_A5A5_A5A5);
        offer(CMD_PUSH,   16'h0000, 64'h1111_2222_3333_4444);
        offer(CMD_LIST,   16'h0000, 64'h0);
        offer(CMD_REMOVE, 16'hFFFF, 64'h0);
        offer(CMD_LIST,   16'h0000, 64'h0);
        offer(CMD_REMOVE, 16'hFFFF, 64'h0);
        offer(CMD_PUSH,   16'h7FFE, 64'h5A5A_5A5A_5A5A_5A5A);
        offer(CMD_REMOVE, 16'h0000, 64'h0);
        offer(CMD_LIST,   16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        offer(CMD_PUSH,   16'h0001, 64'h8000_0000_0000_0001);
        offer(CMD_REMOVE, 16'h0001, 64'h0);
        offer(CMD_LIST,   16'h0000, 64'h0);
        offer(CMD_CLEAR,  16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        offer(CMD_LIST,   16'h0000, 64'h0);

        fill_to_capacity();
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    case ($urandom_range(0, 9))
                        0, 1:    key = KEY_PORT_W'($urandom_range(0, 65535));
                        2:       key = some_held_key();
                        default: key = KEY_PORT_W'($urandom_range(0, 47));
                    endcase
                    offer(CMD_PUSH, key, rand_tag());
                end
            end else if (pick < 65) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    key = ($urandom_range(0, 9) < 7) ? some_held_key()
                                                     : 16'($urandom_range(0, 65535));
                    offer(CMD_REMOVE, key, rand_tag());
                end
            end else if (pick < 80) begin
                offer(CMD_LIST, KEY_PORT_W'($urandom_range(0, 65535)), rand_tag());
            end else if (pick < 86) begin
                offer(CMD_CLEAR, KEY_PORT_W'($urandom_range(0, 65535)), rand_tag());
            end else if (pick < 90) begin
                fill_to_capacity();
            end else begin
                offer(ksr_cmd_t'($urandom_range(0, 3)), KEY_PORT_W'($urandom_range(0, 65535)),
                      rand_tag());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
